// ===== rtl/rlc_pkg.sv =====
// rlc_pkg: shared types and constants for the run-length compressor.
// Command format between classifier and emitter, literal store write port.
// No dependencies.
`default_nettype none

package rlc_pkg;

    localparam int LANES     = 4;
    localparam int CNT_W     = 8;
    localparam int ROW_W     = 6;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

    localparam logic [7:0] HDR_REP = 8'h80;

    typedef enum logic {
        CMD_LIT,
        CMD_REP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic               bank;
        logic [CNT_W-1:0]   cnt;
        logic [7:0]         val;
        logic               last;
        logic               done;
    } t_cmd;

    typedef struct packed {
        logic               en;
        logic               bank;
        logic [ROW_W-1:0]   row;
        logic [1:0]         lane;
        logic [7:0]         data;
    } t_lit_wr;

    typedef struct packed {
        logic en;
        logic bank;
    } t_bank_rel;

    typedef enum logic [2:0] {
        OP_FINISH,
        OP_REP_ADD,
        OP_REP_CLOSE,
        OP_LIT_FLUSH,
        OP_REP_OPEN,
        OP_LIT_PUSH
    } t_front_op;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_bk_state;

endpackage

`default_nettype wire

// ===== rtl/rlc_cmd_fifo.sv =====
// rlc_cmd_fifo: short command queue between classifier and emitter.
// Depends on rlc_pkg.
`default_nettype none

module rlc_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rlc_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output rlc_pkg::t_cmd      o_head,
    output logic               o_empty,
    output logic               o_full
);
    import rlc_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, n_wp;
    logic [Q_PTR_W-1:0] r_rp, n_rp;
    logic [Q_PTR_W:0]   r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + Q_PTR_W'(1);
        end
        if (i_pop) begin
            n_rp = r_rp + Q_PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (Q_PTR_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - (Q_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));

endmodule

`default_nettype wire

// ===== rtl/rlc_front.sv =====
// rlc_front: takes input bytes, keeps the two-byte lookahead and run state,
// writes literal bytes to the store and queues chunk commands. Uses rlc_pkg.
`default_nettype none

module rlc_front #(
    parameter int MAX_CHUNK = 128
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [rlc_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  wire logic                       i_s_tlast,
    output logic                            o_push,
    output rlc_pkg::t_cmd                   o_push_cmd,
    input  wire logic                       i_full,
    output rlc_pkg::t_lit_wr                o_wr,
    input  wire rlc_pkg::t_bank_rel         i_rel
);
    import rlc_pkg::*;

    localparam int CW = $clog2(MAX_CHUNK + 1);

    logic [7:0]    r_q [3];
    logic [7:0]    n_q [3];
    logic [1:0]    r_qn, n_qn;
    logic          r_end, n_end;
    logic          r_active, n_active;
    logic          r_in_rep, n_in_rep;
    logic [7:0]    r_rep_val, n_rep_val;
    logic [CW-1:0] r_rep_cnt, n_rep_cnt;
    logic [CW-1:0] r_lit_cnt, n_lit_cnt;
    logic          r_bank, n_bank;
    logic [1:0]    r_busy, n_busy;
    logic          r_held_v, n_held_v;
    t_cmd          r_held_cmd, n_held_cmd;

    t_front_op     w_op;
    logic          w_eq3;
    logic          w_cmd_v;
    t_cmd          w_cmd;
    logic [CW-1:0] w_inc_lit;
    logic [CW-1:0] w_inc_rep;
    logic [7:0]    w_pos;
    logic          w_stall;
    logic          w_go;
    logic          w_ready;

    // decision for the byte at the head of the lookahead
    always_comb begin
        w_eq3 = (r_qn == 2'd3) && (r_q[0] == r_q[1]) && (r_q[0] == r_q[2]);
        priority if (r_in_rep) begin
            if (r_qn == 2'd0) begin
                w_op = OP_FINISH;
            end else if ((r_q[0] == r_rep_val) && !(r_end && (r_qn == 2'd1))) begin
                w_op = OP_REP_ADD;
            end else begin
                w_op = OP_REP_CLOSE;
            end
        end else if (r_qn == 2'd3) begin
            if (w_eq3) begin
                w_op = (r_lit_cnt != '0) ? OP_LIT_FLUSH : OP_REP_OPEN;
            end else begin
                w_op = OP_LIT_PUSH;
            end
        end else if (r_end) begin
            if (r_qn != 2'd0) begin
                w_op = OP_LIT_PUSH;
            end else if (r_lit_cnt != '0) begin
                w_op = OP_LIT_FLUSH;
            end else begin
                w_op = OP_FINISH;
            end
        end else begin
            w_op = OP_FINISH;
        end
    end

    always_comb begin
        w_inc_lit = r_lit_cnt + CW'(1);
        w_inc_rep = r_rep_cnt + CW'(1);
        w_pos     = 8'(r_lit_cnt) + 8'd1;
        w_cmd_v   = 1'b0;
        w_cmd     = '{kind: CMD_LIT, bank: r_bank, cnt: CNT_W'(r_lit_cnt),
                      val: r_rep_val, last: 1'b0, done: 1'b0};
        unique case (w_op)
            OP_REP_ADD: begin
                if (w_inc_rep == CW'(MAX_CHUNK)) begin
                    w_cmd_v   = 1'b1;
                    w_cmd.kind = CMD_REP;
                    w_cmd.cnt  = CNT_W'(w_inc_rep);
                end
            end
            OP_REP_CLOSE: begin
                if (r_rep_cnt != '0) begin
                    w_cmd_v   = 1'b1;
                    w_cmd.kind = CMD_REP;
                    w_cmd.cnt  = CNT_W'(r_rep_cnt);
                end
            end
            OP_LIT_FLUSH: begin
                w_cmd_v = 1'b1;
            end
            OP_REP_OPEN: begin
                if (MAX_CHUNK == 1) begin
                    w_cmd_v   = 1'b1;
                    w_cmd.kind = CMD_REP;
                    w_cmd.cnt  = CNT_W'(1);
                    w_cmd.val  = r_q[0];
                end
            end
            OP_LIT_PUSH: begin
                if (w_inc_lit == CW'(MAX_CHUNK)) begin
                    w_cmd_v  = 1'b1;
                    w_cmd.cnt = CNT_W'(w_inc_lit);
                end
            end
            OP_FINISH: begin
            end
            default: begin
            end
        endcase
        w_stall = ((w_op == OP_LIT_PUSH) && r_busy[r_bank]) ||
                  (r_held_v && i_full && (w_cmd_v || (w_op == OP_FINISH)));
        w_go    = r_active && !w_stall;
    end

    always_comb begin
        n_q        = r_q;
        n_qn       = r_qn;
        n_end      = r_end;
        n_active   = r_active;
        n_in_rep   = r_in_rep;
        n_rep_val  = r_rep_val;
        n_rep_cnt  = r_rep_cnt;
        n_lit_cnt  = r_lit_cnt;
        n_bank     = r_bank;
        n_busy     = r_busy;
        n_held_v   = r_held_v;
        n_held_cmd = r_held_cmd;
        o_push     = 1'b0;
        o_push_cmd = r_held_cmd;
        o_wr       = '{en: 1'b0, bank: r_bank, row: w_pos[7:2], lane: w_pos[1:0],
                       data: r_q[0]};
        w_ready    = !r_active;

        if (i_rel.en) begin
            n_busy[i_rel.bank] = 1'b0;
        end

        if (w_go) begin
            unique case (w_op)
                OP_REP_ADD: begin
                    n_rep_cnt = w_cmd_v ? '0 : w_inc_rep;
                    n_q[0]    = r_q[1];
                    n_q[1]    = r_q[2];
                    n_qn      = r_qn - 2'd1;
                end
                OP_REP_CLOSE: begin
                    n_rep_cnt = '0;
                    n_in_rep  = 1'b0;
                end
                OP_LIT_FLUSH: begin
                    n_lit_cnt      = '0;
                    n_busy[r_bank] = 1'b1;
                    n_bank         = ~r_bank;
                end
                OP_REP_OPEN: begin
                    n_in_rep  = 1'b1;
                    n_rep_val = r_q[0];
                    n_rep_cnt = w_cmd_v ? '0 : CW'(1);
                    n_q[0]    = r_q[1];
                    n_q[1]    = r_q[2];
                    n_qn      = r_qn - 2'd1;
                end
                OP_LIT_PUSH: begin
                    o_wr.en = 1'b1;
                    if (w_cmd_v) begin
                        n_lit_cnt      = '0;
                        n_busy[r_bank] = 1'b1;
                        n_bank         = ~r_bank;
                    end else begin
                        n_lit_cnt = w_inc_lit;
                    end
                    n_q[0] = r_q[1];
                    n_q[1] = r_q[2];
                    n_qn   = r_qn - 2'd1;
                end
                OP_FINISH: begin
                    if (r_held_v) begin
                        o_push          = 1'b1;
                        o_push_cmd.last = 1'b1;
                        o_push_cmd.done = r_end;
                        n_held_v        = 1'b0;
                    end
                    n_active = 1'b0;
                    if (r_end) begin
                        n_qn      = '0;
                        n_in_rep  = 1'b0;
                        n_rep_val = '0;
                        n_rep_cnt = '0;
                        n_lit_cnt = '0;
                    end
                    w_ready = 1'b1;
                end
                default: begin
                end
            endcase
            if (w_cmd_v) begin
                if (r_held_v) begin
                    o_push = 1'b1;
                end
                n_held_cmd = w_cmd;
                n_held_v   = 1'b1;
            end
        end

        // accept overlaps the wrap-up of the previous byte
        if (i_s_tvalid && w_ready) begin
            n_q[n_qn] = i_s_tdata;
            n_qn      = n_qn + 2'd1;
            n_end     = i_s_tlast;
            n_active  = 1'b1;
        end
    end

    assign o_s_tready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn      <= '0;
            r_end     <= 1'b0;
            r_active  <= 1'b0;
            r_in_rep  <= 1'b0;
            r_rep_val <= '0;
            r_rep_cnt <= '0;
            r_lit_cnt <= '0;
            r_bank    <= 1'b0;
            r_busy    <= '0;
            r_held_v  <= 1'b0;
        end else begin
            r_qn      <= n_qn;
            r_end     <= n_end;
            r_active  <= n_active;
            r_in_rep  <= n_in_rep;
            r_rep_val <= n_rep_val;
            r_rep_cnt <= n_rep_cnt;
            r_lit_cnt <= n_lit_cnt;
            r_bank    <= n_bank;
            r_busy    <= n_busy;
            r_held_v  <= n_held_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_held_cmd <= n_held_cmd;
    end

endmodule

`default_nettype wire

// ===== rtl/rlc_back.sv =====
// rlc_back: literal store (two banks) and word emitter with output register.
// Turns queued chunk commands into words of one to four bytes. Uses rlc_pkg.
`default_nettype none

module rlc_back #(
    parameter int MAX_CHUNK = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire rlc_pkg::t_lit_wr               i_wr,
    input  wire rlc_pkg::t_cmd                  i_head,
    input  wire logic                           i_empty,
    output logic                                o_pop,
    output rlc_pkg::t_bank_rel                  o_rel,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [rlc_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic                                o_m_tlast
);
    import rlc_pkg::*;

    localparam int ROWS  = (MAX_CHUNK + 4) / 4;
    localparam int DEPTH = 2 * ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [LANES-1:0][7:0] r_mem [DEPTH];
    logic [LANES-1:0][7:0] r_rd_data;

    t_bk_state             r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [ROW_W-1:0]      r_row, n_row;
    logic                  r_out_valid, n_out_valid;
    logic [LANES-1:0][7:0] r_out_bytes, n_out_bytes;
    logic [2:0]            r_out_cnt, n_out_cnt;
    logic                  r_out_last, n_out_last;
    logic                  r_out_done, n_out_done;

    logic                  w_rd_en;
    logic                  w_rd_bank;
    logic [ROW_W-1:0]      w_rd_row;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic                  w_free;
    logic [8:0]            w_total;
    logic [8:0]            w_rem;
    logic                  w_final;
    logic [2:0]            w_cnt;
    logic [LANES-1:0][7:0] w_bytes;

    assign w_wr_addr = i_wr.bank ? (AW'(ROWS) + AW'(i_wr.row)) : AW'(i_wr.row);
    assign w_rd_addr = w_rd_bank ? (AW'(ROWS) + AW'(w_rd_row)) : AW'(w_rd_row);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[w_wr_addr][i_wr.lane] <= i_wr.data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // word under construction
    always_comb begin
        w_free  = !r_out_valid || i_m_tready;
        w_total = (r_cmd.kind == CMD_LIT) ? (9'(r_cmd.cnt) + 9'd1) : 9'd2;
        w_rem   = w_total - 9'({r_row, 2'b00});
        w_final = (w_rem <= 9'(LANES));
        w_cnt   = w_final ? w_rem[2:0] : 3'(LANES);
        if (r_cmd.kind == CMD_LIT) begin
            w_bytes = r_rd_data;
            if (r_row == '0) begin
                w_bytes[0] = {1'b0, 7'(r_cmd.cnt - 8'd1)};
            end
        end else begin
            w_bytes    = '0;
            w_bytes[0] = HDR_REP | {1'b0, 7'(r_cmd.cnt - 8'd1)};
            w_bytes[1] = r_cmd.val;
        end
        for (int k = 0; k < LANES; k++) begin
            if (3'(k) >= w_cnt) begin
                w_bytes[k] = '0;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_row       = r_row;
        n_out_valid = r_out_valid;
        n_out_bytes = r_out_bytes;
        n_out_cnt   = r_out_cnt;
        n_out_last  = r_out_last;
        n_out_done  = r_out_done;
        o_pop       = 1'b0;
        o_rel       = '{en: 1'b0, bank: r_cmd.bank};
        w_rd_en     = 1'b0;
        w_rd_bank   = r_cmd.bank;
        w_rd_row    = r_row + ROW_W'(1);

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_head;
                    n_row     = '0;
                    w_rd_en   = (i_head.kind == CMD_LIT);
                    w_rd_bank = i_head.bank;
                    w_rd_row  = '0;
                    n_state   = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_bytes = w_bytes;
                    n_out_cnt   = w_cnt;
                    n_out_last  = w_final && r_cmd.last;
                    n_out_done  = w_final && r_cmd.done;
                    if (w_final) begin
                        o_rel.en = (r_cmd.kind == CMD_LIT);
                        n_state  = BK_IDLE;
                    end else begin
                        n_row   = r_row + ROW_W'(1);
                        w_rd_en = 1'b1;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_row       <= n_row;
        r_out_bytes <= n_out_bytes;
        r_out_cnt   <= n_out_cnt;
        r_out_last  <= n_out_last;
        r_out_done  <= n_out_done;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_last, r_out_cnt, r_out_bytes};
    assign o_m_tlast  = r_out_done;

endmodule

`default_nettype wire

// ===== rtl/rle_literal_repeat_compressor_top.sv =====
// Run-length compressor: one byte in, chunks out (header = count-1, bit 7 set for a repeat) as 1..4 byte words.
// Front end: each byte takes a decision step, and its wrap-up overlaps the next byte's transfer;
// a run close or a literal flush ahead of a repeat adds a step, and stream end adds closing steps;
// emitter gives one word a cycle while the output is ready, and returns to idle between chunks.
// Reset: synchronous, active low; clears run state and queue, leaves the literal store.
`default_nettype none

module rle_literal_repeat_compressor_top #(
    parameter int MAX_CHUNK = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [7:0] data_byte
    input  wire logic [rlc_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  wire logic                           i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [7:0] byte_0, [15:8] byte_1, [23:16] byte_2, [31:24] byte_3,
    // [34:32] byte_count, [35] last_of_burst, [39:36] zero
    output logic [rlc_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                                o_m_axis_tlast
);
    import rlc_pkg::*;

    logic      w_push;
    t_cmd      w_push_cmd;
    logic      w_full;
    logic      w_empty;
    logic      w_pop;
    t_cmd      w_head;
    t_lit_wr   w_wr;
    t_bank_rel w_rel;

    rlc_front #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tlast  (i_s_axis_tlast),
        .o_push     (w_push),
        .o_push_cmd (w_push_cmd),
        .i_full     (w_full),
        .o_wr       (w_wr),
        .i_rel      (w_rel)
    );

    rlc_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    rlc_back #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_wr),
        .i_head     (w_head),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_rel      (w_rel),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("command queue underflow");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tdata[35])
        else $error("stream end word not marked as end of burst");

    a_word_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[34:32] != 3'd0 &&
                             o_m_axis_tdata[34:32] <= 3'd4))
        else $error("word byte count out of range");
`endif

endmodule

`default_nettype wire
